// ===== hw/rtl/clws_pkg.sv =====
`default_nettype none
package clws_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY      = 8'h06;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_FN_RESET   = 8'h30;
    localparam logic [7:0] CMD_FN_SET8    = 8'h38;
    localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
    localparam logic [7:0] LINE_TWO_ADDR  = 8'h40;

    localparam logic [13:0] WAIT_CURSOR_US = 14'd80;

    localparam logic [1:0] FUNC_INIT = 2'd0;
    localparam logic [1:0] FUNC_MSG  = 2'd1;
    localparam logic [1:0] FUNC_CHAR = 2'd2;

    localparam logic SEL_INSTR = 1'b0;
    localparam logic SEL_DATA  = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_MSG     = 2'd1,
        OP_CHAR    = 2'd2,
        OP_CHAR_L2 = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] code;
    } t_cmd;

    typedef struct packed {
        logic  push;
        t_cmd  cmd;
    } t_push;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  bus_byte;
        logic        select_switched;
        logic [15:0] wait_before_us;
        logic [13:0] wait_after_us;
        logic        last_of_run;
    } t_write;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = CMD_FN_RESET;
            3'd3:             b = CMD_FN_SET8;
            3'd4:             b = CMD_DISP_OFF;
            3'd5:             b = CMD_CLEAR;
            3'd6:             b = CMD_ENTRY;
            default:          b = CMD_DISP_ON;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] init_before(input logic [2:0] idx);
        return (idx == 3'd0) ? 16'd50000 : 16'd0;
    endfunction

    function automatic logic [13:0] init_after(input logic [2:0] idx);
        logic [13:0] a;
        case (idx)
            3'd0:       a = 14'd10000;
            3'd1, 3'd2: a = 14'd200;
            default:    a = 14'd80;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/clws_in_if.sv =====
`default_nettype none
interface clws_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] msg_length;

    modport source (output valid, output func, output char_code, output msg_length,
                    input ready);
    modport sink   (input valid, input func, input char_code, input msg_length,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clws_out_if.sv =====
`default_nettype none
interface clws_out_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic        select_switched;
    logic [15:0] wait_before_us;
    logic [13:0] wait_after_us;
    logic        last_of_run;

    modport source (output valid, output reg_select, output bus_byte,
                    output select_switched, output wait_before_us,
                    output wait_after_us, output last_of_run, input ready);
    modport sink   (input valid, input reg_select, input bus_byte,
                    input select_switched, input wait_before_us,
                    input wait_after_us, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clws_queue.sv =====
`default_nettype none
module clws_queue
    import clws_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_cmd       o_head
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/clws_front.sv =====
`default_nettype none
module clws_front
    import clws_pkg::*;
#(
    parameter int LINE_CHARS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clws_in_if.sink    i_in,
    input  wire logic  i_full,
    output t_push      o_push
);

    localparam int PW = $clog2(2 * LINE_CHARS + 1);
    localparam logic [7:0]    MAX_LEN  = 8'(2 * LINE_CHARS);
    localparam logic [PW-1:0] LINE_POS = PW'(LINE_CHARS);

    logic [PW-1:0] r_position;
    logic [PW-1:0] r_length;
    logic          r_rejected;
    logic          accept;
    logic          char_ok;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign char_ok    = !r_rejected && (r_position < r_length);

    always_comb begin
        o_push.push     = 1'b0;
        o_push.cmd.op   = OP_CHAR;
        o_push.cmd.code = i_in.char_code;
        if (accept) begin
            case (i_in.func)
                FUNC_INIT: begin
                    o_push.push   = 1'b1;
                    o_push.cmd.op = OP_INIT;
                end
                FUNC_MSG: begin
                    o_push.push   = 1'b1;
                    o_push.cmd.op = OP_MSG;
                end
                FUNC_CHAR: begin
                    o_push.push   = char_ok;
                    o_push.cmd.op = (r_position == LINE_POS) ? OP_CHAR_L2 : OP_CHAR;
                end
                default: o_push.push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_length   <= '0;
            r_rejected <= 1'b0;
        end else if (accept) begin
            if (i_in.func == FUNC_MSG) begin
                r_position <= '0;
                if (i_in.msg_length > MAX_LEN) begin
                    r_rejected <= 1'b1;
                    r_length   <= '0;
                end else begin
                    r_rejected <= 1'b0;
                    r_length   <= PW'(i_in.msg_length);
                end
            end else if (i_in.func == FUNC_CHAR && char_ok) begin
                r_position <= r_position + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/clws_back.sv =====
`default_nettype none
module clws_back
    import clws_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_cmd  i_head,
    output logic       o_pop,
    clws_out_if.source o_out
);

    logic [2:0] r_step;
    logic       r_last_sel;
    logic       r_valid;
    t_write     r_write;
    t_write     w;
    logic       fire;

    always_comb begin
        w.reg_select      = SEL_INSTR;
        w.bus_byte        = i_head.code;
        w.select_switched = r_last_sel;
        w.wait_before_us  = '0;
        w.wait_after_us   = '0;
        w.last_of_run     = 1'b1;
        unique case (i_head.op)
            OP_INIT: begin
                w.bus_byte        = init_byte(r_step);
                w.wait_before_us  = init_before(r_step);
                w.wait_after_us   = init_after(r_step);
                // init treats the select line as coming from data
                w.select_switched = (r_step == 3'd0) || r_last_sel;
                w.last_of_run     = (r_step == 3'd7);
            end
            OP_MSG: begin
                w.bus_byte    = (r_step == 3'd0) ? CMD_CLEAR : CMD_HOME;
                w.last_of_run = (r_step == 3'd1);
            end
            OP_CHAR: begin
                w.reg_select      = SEL_DATA;
                w.select_switched = !r_last_sel;
            end
            OP_CHAR_L2: begin
                if (r_step == 3'd0) begin
                    w.bus_byte      = CMD_SET_CURSOR | LINE_TWO_ADDR;
                    w.wait_after_us = WAIT_CURSOR_US;
                    w.last_of_run   = 1'b0;
                end else begin
                    w.reg_select      = SEL_DATA;
                    w.select_switched = !r_last_sel;
                end
            end
            default: w.last_of_run = 1'b1;
        endcase
    end

    assign fire  = !i_empty && (!r_valid || o_out.ready);
    assign o_pop = fire && w.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_last_sel <= SEL_INSTR;
            r_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_valid    <= 1'b1;
                r_last_sel <= w.reg_select;
                r_step     <= w.last_of_run ? 3'd0 : r_step + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_write <= w;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.reg_select      = r_write.reg_select;
    assign o_out.bus_byte        = r_write.bus_byte;
    assign o_out.select_switched = r_write.select_switched;
    assign o_out.wait_before_us  = r_write.wait_before_us;
    assign o_out.wait_after_us   = r_write.wait_after_us;
    assign o_out.last_of_run     = r_write.last_of_run;

endmodule
`default_nettype wire

// ===== hw/rtl/char_lcd_write_sequencer_unit.sv =====
`default_nettype none
// Write sequencer for a two-line character LCD in 8-bit mode. Each input beat
// is an init request, a message start or one message character; the block
// answers with bus-write beats (select level, data byte, waits, select-change
// flag), the final beat of each request marked by last_of_run. An input beat
// is taken every cycle while the four-entry command queue has room; the write
// engine emits one bus write per cycle while the queue is non-empty and ready
// does not stall it. Writes per request: 8 (init), 2 (message start or first
// line-two character), 1 (other chars), 0 (dropped chars, unused selector).
module char_lcd_write_sequencer_unit
    import clws_pkg::*;
#(
    parameter int LINE_CHARS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clws_in_if.sink    i_in,
    clws_out_if.source o_out
);

    t_push push;
    logic  full;
    logic  empty;
    logic  pop;
    t_cmd  head;

    clws_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    clws_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_head (head)
    );

    clws_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_head (head),
        .o_pop  (pop),
        .o_out  (o_out)
    );

    a_data_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.reg_select |-> o_out.last_of_run)
        else $error("data write not last of run");

    a_data_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.reg_select |->
            o_out.wait_before_us == 16'd0 && o_out.wait_after_us == 14'd0)
        else $error("data write carries a wait");

    a_startup_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.wait_before_us != 16'd0 |->
            o_out.select_switched && !o_out.reg_select)
        else $error("start-up write without select switch");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule
`default_nettype wire
